// ===== hdl/cft_pkg.sv =====
// Shared types, constants and the CRC-15 update for the CAN frame transmitter.
package cft_pkg;

    localparam int unsigned MAX_PAYLOAD_BYTES = 8;
    localparam int unsigned TRAILER_BITS      = 10;
    localparam int unsigned POS_W             = 7;
    localparam int unsigned ID_W              = 11;
    localparam int unsigned LEN_W             = 4;
    localparam int unsigned PAYLOAD_W         = 64;
    localparam int unsigned CRC_W             = 15;
    localparam int unsigned OUTCOME_W         = 2;

    localparam logic [POS_W-1:0] ID_LAST_POS    = 7'd11;
    localparam logic [POS_W-1:0] CTRL_LAST_POS  = 7'd14;
    localparam logic [POS_W-1:0] LEN_LAST_POS   = 7'd18;
    localparam logic [POS_W-1:0] DATA_START_POS = 7'd19;
    localparam logic [POS_W-1:0] ARB_LAST_POS   = 7'd12;
    localparam logic [POS_W-1:0] CRC_LEN        = 7'd15;
    localparam logic [POS_W-1:0] TRAILER_LEN    = POS_W'(TRAILER_BITS);

    localparam logic [CRC_W-1:0] CRC15_POLY = 15'h4599;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BIT   = 1'b1;

    localparam logic [OUTCOME_W-1:0] OUTCOME_ACKED    = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_NO_ACK   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_ARB_LOST = 2'd2;

    typedef struct packed {
        logic                 opcode;
        logic [ID_W-1:0]      frame_id;
        logic [LEN_W-1:0]     frame_length;
        logic [PAYLOAD_W-1:0] payload;
        logic [CRC_W-1:0]     crc_value;
        logic                 crc_supplied;
        logic                 bus_level;
    } item_t;

    typedef struct packed {
        logic                 tx_level;
        logic                 frame_done;
        logic [OUTCOME_W-1:0] outcome;
        logic                 busy_res;
    } result_t;

    function automatic logic [CRC_W-1:0] crc15_bit(input logic [CRC_W-1:0] crc,
                                                   input logic bit_in);
        logic [CRC_W-1:0] shifted;
        begin
            shifted = {crc[CRC_W-2:0], 1'b0};
            if (bit_in ^ crc[CRC_W-1])
            begin
                shifted = shifted ^ CRC15_POLY;
            end
            return shifted;
        end
    endfunction

endpackage

// ===== hdl/cft_bit_engine.sv =====
// Frame state and per-item bit selection, CRC, acknowledge and arbitration logic.
module cft_bit_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           arb_monitor,
    input  cft_pkg::item_t item,
    output cft_pkg::result_t result
);
    import cft_pkg::*;

    logic [POS_W-1:0]     bit_pos_reg, bit_pos_next;
    logic                 active_reg, active_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [LEN_W-1:0]     length_reg, length_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [CRC_W-1:0]     crc_shift_reg, crc_shift_next;
    logic [CRC_W-1:0]     given_crc_reg, given_crc_next;
    logic                 use_given_reg, use_given_next;
    logic                 ack_missing_reg, ack_missing_next;

    logic [POS_W-1:0] data_end;
    logic [POS_W-1:0] crc_end;
    logic [POS_W-1:0] ack_pos;
    logic [POS_W-1:0] last_pos;
    logic [POS_W-1:0] id_off;
    logic [POS_W-1:0] len_off;
    logic [POS_W-1:0] pay_off;
    logic [POS_W-1:0] crc_off;
    logic [CRC_W-1:0] crc_sel;
    logic             tx_bit;

    always_comb
    begin
        data_end = DATA_START_POS + {length_reg, 3'b000};
        crc_end  = data_end + CRC_LEN;
        ack_pos  = crc_end + 7'd1;
        last_pos = crc_end + 7'd2 + TRAILER_LEN;
        id_off   = ID_LAST_POS - bit_pos_reg;
        len_off  = LEN_LAST_POS - bit_pos_reg;
        pay_off  = data_end - 7'd1 - bit_pos_reg;
        crc_off  = crc_end - 7'd1 - bit_pos_reg;
        crc_sel  = use_given_reg ? given_crc_reg : crc_shift_reg;

        if (bit_pos_reg == '0)
        begin
            tx_bit = 1'b0;
        end
        else if (bit_pos_reg <= ID_LAST_POS)
        begin
            tx_bit = id_reg[id_off[3:0]];
        end
        else if (bit_pos_reg <= CTRL_LAST_POS)
        begin
            tx_bit = 1'b0;
        end
        else if (bit_pos_reg <= LEN_LAST_POS)
        begin
            tx_bit = length_reg[len_off[1:0]];
        end
        else if (bit_pos_reg < data_end)
        begin
            tx_bit = payload_reg[pay_off[5:0]];
        end
        else if (bit_pos_reg < crc_end)
        begin
            tx_bit = crc_sel[crc_off[3:0]];
        end
        else
        begin
            tx_bit = 1'b1;
        end
    end

    always_comb
    begin
        bit_pos_next     = bit_pos_reg;
        active_next      = active_reg;
        id_next          = id_reg;
        length_next      = length_reg;
        payload_next     = payload_reg;
        crc_shift_next   = crc_shift_reg;
        given_crc_next   = given_crc_reg;
        use_given_next   = use_given_reg;
        ack_missing_next = ack_missing_reg;
        result           = '{tx_level: 1'b1, frame_done: 1'b0,
                             outcome: OUTCOME_ACKED, busy_res: 1'b0};

        if (step)
        begin
            if (item.opcode == OP_START)
            begin
                id_next          = item.frame_id;
                length_next      = (item.frame_length > LEN_W'(MAX_PAYLOAD_BYTES)) ?
                                   LEN_W'(MAX_PAYLOAD_BYTES) : item.frame_length;
                payload_next     = item.payload;
                given_crc_next   = item.crc_value;
                use_given_next   = item.crc_supplied;
                crc_shift_next   = '0;
                ack_missing_next = 1'b0;
                bit_pos_next     = '0;
                active_next      = 1'b1;
            end
            else if (active_reg)
            begin
                result.tx_level = tx_bit;
                result.busy_res = 1'b1;
                if (bit_pos_reg < data_end)
                begin
                    crc_shift_next = crc15_bit(crc_shift_reg, tx_bit);
                end
                if ((bit_pos_reg == ack_pos) && item.bus_level)
                begin
                    ack_missing_next = 1'b1;
                end
                if (arb_monitor && (bit_pos_reg <= ARB_LAST_POS) &&
                    (item.bus_level != tx_bit))
                begin
                    result.frame_done = 1'b1;
                    result.outcome    = OUTCOME_ARB_LOST;
                    active_next       = 1'b0;
                end
                else if (bit_pos_reg >= last_pos)
                begin
                    result.frame_done = 1'b1;
                    result.outcome    = ack_missing_reg ? OUTCOME_NO_ACK : OUTCOME_ACKED;
                    active_next       = 1'b0;
                end
                else
                begin
                    bit_pos_next = bit_pos_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg     <= '0;
            active_reg      <= 1'b0;
            id_reg          <= '0;
            length_reg      <= '0;
            payload_reg     <= '0;
            crc_shift_reg   <= '0;
            given_crc_reg   <= '0;
            use_given_reg   <= 1'b0;
            ack_missing_reg <= 1'b0;
        end
        else
        begin
            bit_pos_reg     <= bit_pos_next;
            active_reg      <= active_next;
            id_reg          <= id_next;
            length_reg      <= length_next;
            payload_reg     <= payload_next;
            crc_shift_reg   <= crc_shift_next;
            given_crc_reg   <= given_crc_next;
            use_given_reg   <= use_given_next;
            ack_missing_reg <= ack_missing_next;
        end
    end

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (bit_pos_reg <= last_pos))
        else $error("bit position ran past the end of the frame");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.opcode == OP_START) |=> (active_reg && bit_pos_reg == '0 &&
                                               crc_shift_reg == '0 && !ack_missing_reg))
        else $error("start request did not restart the frame");

    a_len_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LEN_W'(MAX_PAYLOAD_BYTES))
        else $error("stored length above the payload limit");

endmodule

// ===== hdl/can_frame_transmitter_top.sv =====
// Top level of the CAN base-frame transmitter: request register, bit engine, result register.
//
// Requests enter on in_valid/in_stall. A start request loads the identifier, length,
// payload and CRC choice and gives no result; a bit-time request returns one result
// (tx_level, frame_done, outcome, busy_res) on out_valid/out_stall.
// A request is held in the input register; then, once it may advance, the bit engine updates
// the frame state and writes the result register, whose valid flag drives out_valid.
// One request is taken every cycle while in_stall is low; the frame state loop in the bit
// engine, a single shift and compare per bit, sets that rate.
// When out_stall holds a waiting result, a bit-time request stays in the input register
// and in_stall rises; start requests still pass. Results are never dropped.
// The arbitration monitor register is written on cfg_valid/cfg_ready and is always ready;
// it should only be written while no request is in flight.
// Reset clears both registers' valid flags, makes the transmitter idle and sets the
// arbitration monitor on. A bit time while idle returns a recessive level.
module can_frame_transmitter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [cft_pkg::ID_W-1:0]        frame_id,
    input  logic [cft_pkg::LEN_W-1:0]       frame_length,
    input  logic [cft_pkg::PAYLOAD_W-1:0]   payload,
    input  logic [cft_pkg::CRC_W-1:0]       crc_value,
    input  logic                            crc_supplied,
    input  logic                            bus_level,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            tx_level,
    output logic                            frame_done,
    output logic [cft_pkg::OUTCOME_W-1:0]   outcome,
    output logic                            busy_res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data
);
    import cft_pkg::*;

    logic    req_valid_reg, req_valid_next;
    item_t   req_reg;
    logic    res_valid_reg, res_valid_next;
    result_t res_reg;
    result_t res_comb;
    logic    arb_mon_reg;
    logic    advance;
    logic    in_accept;
    logic    res_load;

    always_comb
    begin
        advance   = req_valid_reg &&
                    ((req_reg.opcode == OP_START) || !res_valid_reg || !out_stall);
        in_stall  = req_valid_reg && !advance;
        in_accept = in_valid && !in_stall;
        res_load  = advance && (req_reg.opcode == OP_BIT);

        req_valid_next = in_accept ? 1'b1 : (advance ? 1'b0 : req_valid_reg);
        res_valid_next = res_load ? 1'b1 :
                         ((res_valid_reg && !out_stall) ? 1'b0 : res_valid_reg);
    end

    cft_bit_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .arb_monitor (arb_mon_reg),
        .item        (req_reg),
        .result      (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            arb_mon_reg   <= 1'b1;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                arb_mon_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg <= '{opcode: opcode, frame_id: frame_id, frame_length: frame_length,
                         payload: payload, crc_value: crc_value,
                         crc_supplied: crc_supplied, bus_level: bus_level};
        end
        if (res_load)
        begin
            res_reg <= res_comb;
        end
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = res_valid_reg;
    assign tx_level   = res_reg.tx_level;
    assign frame_done = res_reg.frame_done;
    assign outcome    = res_reg.outcome;
    assign busy_res   = res_reg.busy_res;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.frame_done) |-> res_reg.busy_res)
        else $error("frame end reported outside a frame");

    a_outcome_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.frame_done) |-> (res_reg.outcome == OUTCOME_ACKED))
        else $error("outcome set without frame end");

    a_idle_recessive: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.busy_res) |-> res_reg.tx_level)
        else $error("dominant level driven while idle");

    a_stall_blocks_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && req_reg.opcode == OP_BIT && res_valid_reg && out_stall)
        |-> in_stall)
        else $error("bit request advanced over a waiting result");

endmodule
